FILE: src/pfre_pkg.sv
// pfre_pkg: shared constants for the page fault replacement engine.
// Codes for actions, policies and register indexes, reset values, LFSR constants.
// No dependencies.
package pfre_pkg;

   localparam int DEF_MAX_PAGES  = 256;
   localparam int DEF_MAX_FRAMES = 64;

   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int RIGHTS_W  = 3;
   localparam int LFSR_W    = 16;

   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

   // result action codes
   localparam logic [1:0] ACT_UPGRADE = 2'd0;
   localparam logic [1:0] ACT_LOAD    = 2'd1;
   localparam logic [1:0] ACT_NONE    = 2'd2;

   // victim policies; the unused code behaves as round robin
   localparam logic [1:0] POL_RANDOM = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;
   localparam logic [1:0] POL_ROUND  = 2'd2;

   // register indexes (word address)
   localparam logic [1:0] REG_POLICY = 2'd0;
   localparam logic [1:0] REG_PAGES  = 2'd1;
   localparam logic [1:0] REG_FRAMES = 2'd2;

   localparam logic [1:0] POLICY_RESET = POL_FIFO;
   localparam logic [8:0] PAGES_RESET  = 9'd256;
   localparam logic [6:0] FRAMES_RESET = 7'd64;

   // rights bits
   localparam logic [RIGHTS_W-1:0] RIGHTS_NONE = 3'b000;
   localparam logic [RIGHTS_W-1:0] RIGHTS_R    = 3'b001;
   localparam logic [RIGHTS_W-1:0] RIGHTS_RW   = 3'b011;
   localparam logic [RIGHTS_W-1:0] RIGHTS_RWX  = 3'b111;

endpackage

FILE: src/pfre_ram.sv
// pfre_ram: simple dual-port memory, one write and one registered read per cycle.
// Used for the page table and the load order ring. No dependencies.
module pfre_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pfre_mod.sv
// pfre_mod: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on pfre_pkg for the dividend width.
module pfre_mod
   import pfre_pkg::*;
#(
   parameter int DVW = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LFSR_W-1:0] dividend,
   input  logic [DVW-1:0]    divisor,
   output logic              done,
   output logic [DVW-1:0]    remainder
);

   localparam int CW = $clog2(LFSR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DVW-1:0]    rem_ff, rem_in;
   logic [LFSR_W-1:0] dvd_ff, dvd_in;
   logic [DVW:0]      shifted;

   always_comb begin
      shifted = {rem_ff, dvd_ff[LFSR_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = DVW'(shifted - {1'b0, divisor});
         end else begin
            rem_in = DVW'(shifted);
         end
         dvd_in = {dvd_ff[LFSR_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/page_fault_replacement_engine.sv
// page_fault_replacement_engine: top level, sequencer, counters and CSR block.
// Depends on pfre_pkg, pfre_ram and pfre_mod.
//
//   channel | ports        | handshake     | carries
//   --------+--------------+---------------+---------------------------------
//   request | req_*        | valid/ready   | fault_page
//   result  | rsp_*        | valid/ready   | action, frame, rights, victim, totals
//   config  | csr_*        | APB, pready=1 | policy_mode, pages_in_use, frames_in_use
//
// From acceptance to the result, req_ready stays low. A page beyond the managed
// count goes straight to the result; a mapped page is looked up; a free frame is loaded;
// FIFO checks the ring head for a victim. Random and round robin run the serial remainder
// unit, then probe the page table one page at a time until a victim or a full pass.
// After reset the page table is cleared one entry a cycle, with req_ready low.
// A held result stalls the sequencer until the output register frees.
module page_fault_replacement_engine
   import pfre_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_fault_page,
   // result
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_action,
   output logic [5:0]        rsp_frame,
   output logic [2:0]        rsp_new_rights,
   output logic              rsp_evicted,
   output logic [7:0]        rsp_evicted_page,
   output logic              rsp_write_back,
   output logic [31:0]       rsp_fault_count,
   output logic [31:0]       rsp_read_count,
   output logic [31:0]       rsp_write_count,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int PW    = $clog2(MAX_PAGES);         // page index
   localparam int NPW   = $clog2(MAX_PAGES + 1);     // page count
   localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int HW    = $clog2(MAX_FRAMES + 1);    // frame count
   localparam int TBL_W = FW + RIGHTS_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_MOD, ST_SCAN_RD, ST_SCAN_CHK,
      ST_FIFO_RD, ST_FIFO_CHK, ST_LOAD, ST_DONE
   } state_type;

   // ---------------- configuration registers ----------------
   logic [1:0] policy_ff;
   logic [8:0] pages_ff;
   logic [6:0] frames_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         pages_ff  <= PAGES_RESET;
         frames_ff <= FRAMES_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_POLICY: policy_ff <= csr_pwdata[1:0];
            REG_PAGES:  pages_ff  <= csr_pwdata[8:0];
            REG_FRAMES: frames_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_POLICY: csr_prdata = CSR_DW'(policy_ff);
         REG_PAGES:  csr_prdata = CSR_DW'(pages_ff);
         REG_FRAMES: csr_prdata = CSR_DW'(frames_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // effective page and frame counts, clamped to 1..MAX
   logic [NPW-1:0] np;
   logic [HW-1:0]  nf;

   always_comb begin
      if (pages_ff == '0) begin
         np = NPW'(1);
      end else if (32'(pages_ff) > MAX_PAGES) begin
         np = NPW'(MAX_PAGES);
      end else begin
         np = NPW'(pages_ff);
      end
      if (frames_ff == '0) begin
         nf = HW'(1);
      end else if (32'(frames_ff) > MAX_FRAMES) begin
         nf = HW'(MAX_FRAMES);
      end else begin
         nf = HW'(frames_ff);
      end
   end

   // ---------------- sequencer state ----------------
   state_type         state_ff, state_in;
   logic [PW-1:0]     page_ff, page_in;
   logic [31:0]       fault_ff, fault_in;
   logic [31:0]       read_ff, read_in;
   logic [31:0]       write_ff, write_in;
   logic [HW-1:0]     hw_ff, hw_in;        // frames 0..hw-1 are in use
   logic [FW-1:0]     head_ff, head_in;
   logic [HW-1:0]     fill_ff, fill_in;
   logic [PW-1:0]     rotate_ff, rotate_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [PW-1:0]     vic_ff, vic_in;
   logic [PW-1:0]     cand_ff, cand_in;
   logic [NPW-1:0]    k_ff, k_in;
   logic [FW-1:0]     fsel_ff, fsel_in;
   logic [PW-1:0]     clr_ff, clr_in;
   logic [1:0]        res_act_ff, res_act_in;
   logic [FW-1:0]     res_frame_ff, res_frame_in;
   logic [2:0]        res_rights_ff, res_rights_in;
   logic              res_ev_ff, res_ev_in;
   logic              res_wb_ff, res_wb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_act_ff, rsp_act_in;
   logic [5:0]        rsp_frame_ff, rsp_frame_in;
   logic [2:0]        rsp_rights_ff, rsp_rights_in;
   logic              rsp_ev_ff, rsp_ev_in;
   logic [7:0]        rsp_evp_ff, rsp_evp_in;
   logic              rsp_wb_ff, rsp_wb_in;
   logic [31:0]       rsp_fc_ff, rsp_fc_in;
   logic [31:0]       rsp_rc_ff, rsp_rc_in;
   logic [31:0]       rsp_wc_ff, rsp_wc_in;

   // memory and shared unit hookups
   logic              tbl_we;
   logic [PW-1:0]     tbl_waddr, tbl_raddr;
   logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;
   logic              ring_we;
   logic [FW-1:0]     ring_waddr;
   logic [PW-1:0]     ring_wdata, ring_rdata;
   logic              mod_start, mod_done;
   logic [LFSR_W-1:0] mod_dividend;
   logic [NPW-1:0]    mod_rem;

   logic [RIGHTS_W-1:0] rd_rights;
   logic [FW-1:0]       rd_frame;
   logic [LFSR_W-1:0]   lfsr_next;
   logic [NPW-1:0]      cand_inc, k_inc;
   logic [PW-1:0]       cand_wrap;
   logic [FW-1:0]       push_head;
   logic [HW-1:0]       push_fill;
   logic [HW:0]         push_sum;
   logic                req_acc;

   assign rd_rights = tbl_rdata[RIGHTS_W-1:0];
   assign rd_frame  = tbl_rdata[TBL_W-1:RIGHTS_W];
   assign lfsr_next = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign cand_inc  = NPW'(cand_ff) + 1'b1;
   assign cand_wrap = (cand_inc == np) ? '0 : PW'(cand_inc);
   assign k_inc     = k_ff + 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;

   // ring push: drop the oldest entry when the ring already holds nf pages
   always_comb begin
      if (fill_ff >= nf) begin
         push_head = (32'(head_ff) == MAX_FRAMES - 1) ? '0 : head_ff + 1'b1;
         push_fill = fill_ff;
      end else begin
         push_head = head_ff;
         push_fill = fill_ff + 1'b1;
      end
      push_sum = (HW+1)'(push_head) + (HW+1)'(push_fill) - 1'b1;
      if (32'(push_sum) >= MAX_FRAMES) begin
         push_sum = push_sum - (HW+1)'(MAX_FRAMES);
      end
   end

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      fault_in      = fault_ff;
      read_in       = read_ff;
      write_in      = write_ff;
      hw_in         = hw_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      rotate_in     = rotate_ff;
      lfsr_in       = lfsr_ff;
      vic_in        = vic_ff;
      cand_in       = cand_ff;
      k_in          = k_ff;
      fsel_in       = fsel_ff;
      clr_in        = clr_ff;
      res_act_in    = res_act_ff;
      res_frame_in  = res_frame_ff;
      res_rights_in = res_rights_ff;
      res_ev_in     = res_ev_ff;
      res_wb_in     = res_wb_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_act_in    = rsp_act_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_rights_in = rsp_rights_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evp_in    = rsp_evp_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_fc_in     = rsp_fc_ff;
      rsp_rc_in     = rsp_rc_ff;
      rsp_wc_in     = rsp_wc_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = page_ff;
      tbl_wdata     = '0;
      tbl_raddr     = PW'(req_fault_page);
      ring_we       = 1'b0;
      ring_waddr    = FW'(push_sum);
      ring_wdata    = page_ff;
      mod_start     = 1'b0;
      mod_dividend  = LFSR_W'(rotate_ff);

      case (state_ff)
         ST_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_PAGES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               page_in       = PW'(req_fault_page);
               fault_in      = fault_ff + 1'b1;
               res_act_in    = ACT_NONE;
               res_frame_in  = '0;
               res_rights_in = RIGHTS_NONE;
               res_ev_in     = 1'b0;
               res_wb_in     = 1'b0;
               vic_in        = '0;
               if (32'(req_fault_page) < 32'(np)) begin
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOOK: begin
            if (rd_rights == RIGHTS_R || rd_rights == RIGHTS_RW) begin
               // read only gains write, read-write gains execute
               res_rights_in = (rd_rights == RIGHTS_R) ? RIGHTS_RW : RIGHTS_RWX;
               res_act_in    = ACT_UPGRADE;
               res_frame_in  = rd_frame;
               tbl_we        = 1'b1;
               tbl_wdata     = {rd_frame, res_rights_in};
               state_in      = ST_DONE;
            end else if (rd_rights != RIGHTS_NONE) begin
               res_rights_in = rd_rights;
               res_frame_in  = rd_frame;
               state_in      = ST_DONE;
            end else if (hw_ff < nf) begin
               fsel_in  = FW'(hw_ff);
               hw_in    = hw_ff + 1'b1;
               state_in = ST_LOAD;
            end else begin
               case (policy_ff)
                  POL_FIFO: begin
                     vic_in   = ring_rdata;
                     state_in = (fill_ff == '0) ? ST_DONE : ST_FIFO_RD;
                  end
                  POL_RANDOM: begin
                     lfsr_in      = lfsr_next;
                     mod_dividend = lfsr_next;
                     mod_start    = 1'b1;
                     state_in     = ST_MOD;
                  end
                  default: begin
                     mod_start = 1'b1;
                     state_in  = ST_MOD;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               cand_in  = PW'(mod_rem);
               k_in     = '0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            tbl_raddr = cand_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (policy_ff != POL_RANDOM) begin
               rotate_in = cand_wrap;
            end
            if (rd_rights != RIGHTS_NONE) begin
               vic_in    = cand_ff;
               res_ev_in = 1'b1;
               res_wb_in = rd_rights[1];
               write_in  = write_ff + 32'(rd_rights[1]);
               fsel_in   = rd_frame;
               tbl_we    = 1'b1;
               tbl_waddr = cand_ff;
               state_in  = ST_LOAD;
            end else if (k_inc == np) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_inc;
               cand_in  = cand_wrap;
               state_in = ST_SCAN_RD;
            end
         end
         ST_FIFO_RD: begin
            tbl_raddr = vic_ff;
            state_in  = ST_FIFO_CHK;
         end
         ST_FIFO_CHK: begin
            if (rd_rights != RIGHTS_NONE) begin
               res_ev_in = 1'b1;
               res_wb_in = rd_rights[1];
               write_in  = write_ff + 32'(rd_rights[1]);
               fsel_in   = rd_frame;
               tbl_we    = 1'b1;
               tbl_waddr = vic_ff;
               state_in  = ST_LOAD;
            end else begin
               vic_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            tbl_we        = 1'b1;
            tbl_wdata     = {fsel_ff, RIGHTS_R};
            read_in       = read_ff + 1'b1;
            ring_we       = 1'b1;
            head_in       = push_head;
            fill_in       = push_fill;
            res_act_in    = ACT_LOAD;
            res_frame_in  = fsel_ff;
            res_rights_in = RIGHTS_R;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_act_in    = res_act_ff;
               rsp_frame_in  = 6'(res_frame_ff);
               rsp_rights_in = res_rights_ff;
               rsp_ev_in     = res_ev_ff;
               rsp_evp_in    = 8'(vic_ff);
               rsp_wb_in     = res_wb_ff;
               rsp_fc_in     = fault_ff;
               rsp_rc_in     = read_ff;
               rsp_wc_in     = write_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fault_ff     <= '0;
         read_ff      <= '0;
         write_ff     <= '0;
         hw_ff        <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rotate_ff    <= '0;
         lfsr_ff      <= LFSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fault_ff     <= fault_in;
         read_ff      <= read_in;
         write_ff     <= write_in;
         hw_ff        <= hw_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rotate_ff    <= rotate_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff       <= page_in;
      vic_ff        <= vic_in;
      cand_ff       <= cand_in;
      k_ff          <= k_in;
      fsel_ff       <= fsel_in;
      res_act_ff    <= res_act_in;
      res_frame_ff  <= res_frame_in;
      res_rights_ff <= res_rights_in;
      res_ev_ff     <= res_ev_in;
      res_wb_ff     <= res_wb_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_rights_ff <= rsp_rights_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evp_ff    <= rsp_evp_in;
      rsp_wb_ff     <= rsp_wb_in;
      rsp_fc_ff     <= rsp_fc_in;
      rsp_rc_ff     <= rsp_rc_in;
      rsp_wc_ff     <= rsp_wc_in;
   end

   // page table: {frame, rights} per page
   pfre_ram #(
      .DEPTH (MAX_PAGES),
      .AW    (PW),
      .DW    (TBL_W)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // load order ring, always read at the head
   pfre_ram #(
      .DEPTH (MAX_FRAMES),
      .AW    (FW),
      .DW    (PW)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (head_ff),
      .rdata (ring_rdata)
   );

   // shared remainder unit: start page for random draws and round robin
   pfre_mod #(
      .DVW (NPW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (np),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_act_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_new_rights   = rsp_rights_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_evicted_page = rsp_evp_ff;
   assign rsp_write_back   = rsp_wb_ff;
   assign rsp_fault_count  = rsp_fc_ff;
   assign rsp_read_count   = rsp_rc_ff;
   assign rsp_write_count  = rsp_wc_ff;

   // ---------------- assertions ----------------
   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      32'(hw_ff) <= MAX_FRAMES)
      else $error("frame high-water mark beyond frame count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_FRAMES)
      else $error("load order ring overfilled");

   a_evict_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ev_ff |-> rsp_act_ff == ACT_LOAD && rsp_rights_ff == RIGHTS_R)
      else $error("eviction without a load");

   a_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ev_ff |-> !rsp_wb_ff && rsp_evp_ff == '0)
      else $error("victim fields set without eviction");

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for page_fault_replacement_engine.
// Holds its own page table model to predict each result; needs pfre_pkg and the RTL.
// Faults go in over req_*, results are checked from rsp_*, registers are set over csr_*.
module testbench
   import pfre_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPAGES    = DEF_MAX_PAGES;
   localparam int NFRAMES   = DEF_MAX_FRAMES;
   // watchdog limit on the length of the whole run
   localparam int CYCLE_CAP = 4_000_000;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  frame;
      logic [2:0]  rights;
      logic        evicted;
      logic [7:0]  victim;
      logic        write_back;
      logic [31:0] faults;
      logic [31:0] reads;
      logic [31:0] writes;
   } fault_answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_fault_page = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_action;
   logic [5:0]        rsp_frame;
   logic [2:0]        rsp_new_rights;
   logic              rsp_evicted;
   logic [7:0]        rsp_evicted_page;
   logic              rsp_write_back;
   logic [31:0]       rsp_fault_count;
   logic [31:0]       rsp_read_count;
   logic [31:0]       rsp_write_count;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   page_fault_replacement_engine DUT (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow of the engine: registers, page table, frame map, load order ring,
   // round robin pointer, LFSR and the three running totals.
   // ---------------------------------------------------------------------------
   logic [1:0]  cfg_policy;
   logic [8:0]  cfg_pages;
   logic [6:0]  cfg_frames;
   logic [2:0]  rights_tab [NPAGES];
   logic [5:0]  frame_tab [NPAGES];
   bit          frame_busy [NFRAMES];
   logic [7:0]  load_ring [NFRAMES];
   int          ring_head, ring_fill, rr_ptr;
   logic [15:0] lfsr;
   logic [31:0] fault_total, read_total, write_total;

   fault_answer_type pending_answers [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;

   function automatic int active_pages();
      if (cfg_pages == 0) return 1;
      return (cfg_pages > NPAGES) ? NPAGES : int'(cfg_pages);
   endfunction

   function automatic int active_frames();
      if (cfg_frames == 0) return 1;
      return (cfg_frames > NFRAMES) ? NFRAMES : int'(cfg_frames);
   endfunction

   // Works out the answer to one fault and updates the shadow state.
   function automatic fault_answer_type predict_fault(logic [7:0] page);
      fault_answer_type a;
      int np, nf, f, v, start, ptr;
      bit found;
      np = active_pages();
      nf = active_frames();
      a = '0;
      a.action = ACT_NONE;
      fault_total++;
      if (page < np) begin
         if (rights_tab[page] == RIGHTS_R || rights_tab[page] == RIGHTS_RW) begin
            rights_tab[page] = (rights_tab[page] == RIGHTS_R) ? RIGHTS_RW : RIGHTS_RWX;
            a.action = ACT_UPGRADE;
            a.rights = rights_tab[page];
            a.frame  = frame_tab[page];
         end else if (rights_tab[page] != RIGHTS_NONE) begin
            // all rights already held: reported, not reloaded
            a.rights = rights_tab[page];
            a.frame  = frame_tab[page];
         end else begin
            found = 0;
            for (f = 0; f < nf; f++) begin
               if (!frame_busy[f]) begin
                  found = 1;
                  break;
               end
            end
            if (!found) begin
               v = 0;
               if (cfg_policy == POL_FIFO) begin
                  if (ring_fill != 0) begin
                     v = load_ring[ring_head];
                     found = (rights_tab[v] != RIGHTS_NONE);
                  end
               end else if (cfg_policy == POL_RANDOM) begin
                  lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                  start = lfsr % np;
                  for (int k = 0; k < np; k++) begin
                     if (rights_tab[(start + k) % np] != RIGHTS_NONE) begin
                        v = (start + k) % np;
                        found = 1;
                        break;
                     end
                  end
               end else begin
                  // round robin, and the unused code behaves the same
                  ptr = rr_ptr % np;
                  for (int k = 0; k < np; k++) begin
                     v = ptr;
                     ptr = (ptr + 1) % np;
                     if (rights_tab[v] != RIGHTS_NONE) begin
                        found = 1;
                        break;
                     end
                  end
                  rr_ptr = ptr;
               end
               if (found) begin
                  a.evicted = 1'b1;
                  a.victim  = v[7:0];
                  if (rights_tab[v][1]) begin
                     a.write_back = 1'b1;
                     write_total++;
                  end
                  f = frame_tab[v];
                  frame_busy[f] = 0;
                  rights_tab[v] = RIGHTS_NONE;
                  frame_tab[v]  = '0;
               end
            end
            if (found) begin
               read_total++;
               frame_tab[page]  = f[5:0];
               rights_tab[page] = RIGHTS_R;
               frame_busy[f]    = 1;
               if (ring_fill >= nf) ring_head = (ring_head + 1) % NFRAMES;
               else ring_fill++;
               load_ring[(ring_head + ring_fill - 1) % NFRAMES] = page;
               a.action = ACT_LOAD;
               a.frame  = f[5:0];
               a.rights = RIGHTS_R;
            end
         end
      end
      a.faults = fault_total;
      a.reads  = read_total;
      a.writes = write_total;
      return a;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers. Everything changes on the falling edge; tasks start and end there.
   // ---------------------------------------------------------------------------
   task automatic send_fault(logic [7:0] page);
      bit ready_seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_fault_page <= page;
      pending_answers.push_back(predict_fault(page));
      // ready is a register output, so its value here holds up to the next edge
      forever begin
         ready_seen = req_ready;
         @(posedge clock);
         if (ready_seen) break;
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_POLICY: cfg_policy = value[1:0];
         REG_PAGES:  cfg_pages  = value[8:0];
         REG_FRAMES: cfg_frames = value[6:0];
         default: ;
      endcase
   endtask

   // Block idle: all answers back and a short margin for the output register.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(logic [1:0] pol, logic [8:0] pages, logic [6:0] frames);
      drain();
      csr_write(REG_POLICY, {30'd0, pol});
      csr_write(REG_PAGES,  {23'd0, pages});
      csr_write(REG_FRAMES, {25'd0, frames});
   endtask

   // Receiver side stall, redrawn every cycle.
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Result checker: each accepted item against the oldest expectation.
   always @(posedge clock) begin
      fault_answer_type exp_a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected item: action %0d frame %0d", rsp_action, rsp_frame);
            error_count++;
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_action !== exp_a.action) begin
               $error("action exp %0d got %0d", exp_a.action, rsp_action);
               error_count++;
            end
            if (rsp_frame !== exp_a.frame) begin
               $error("frame exp %0d got %0d", exp_a.frame, rsp_frame);
               error_count++;
            end
            if (rsp_new_rights !== exp_a.rights) begin
               $error("new_rights exp %0d got %0d", exp_a.rights, rsp_new_rights);
               error_count++;
            end
            if (rsp_evicted !== exp_a.evicted) begin
               $error("evicted exp %0d got %0d", exp_a.evicted, rsp_evicted);
               error_count++;
            end
            if (rsp_evicted_page !== exp_a.victim) begin
               $error("evicted_page exp %0d got %0d", exp_a.victim, rsp_evicted_page);
               error_count++;
            end
            if (rsp_write_back !== exp_a.write_back) begin
               $error("write_back exp %0d got %0d", exp_a.write_back, rsp_write_back);
               error_count++;
            end
            if (rsp_fault_count !== exp_a.faults) begin
               $error("fault_count exp %0d got %0d", exp_a.faults, rsp_fault_count);
               error_count++;
            end
            if (rsp_read_count !== exp_a.reads) begin
               $error("read_count exp %0d got %0d", exp_a.reads, rsp_read_count);
               error_count++;
            end
            if (rsp_write_count !== exp_a.writes) begin
               $error("write_count exp %0d got %0d", exp_a.writes, rsp_write_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Rights climb read -> read/write -> all, then a fault on a full page does
   // nothing; also the top page, a page beyond the managed count and clamping
   // of both counts.
   task automatic test_rights_and_limits();
      send_fault(8'd0);
      send_fault(8'd0);
      send_fault(8'd0);
      send_fault(8'd0);
      send_fault(8'd255);
      send_fault(8'd255);
      set_mode(POL_FIFO, 9'd4, 7'd1);
      send_fault(8'd200);              // beyond managed pages
      send_fault(8'd1);                // evicts page 0 with write-back
      send_fault(8'd2);
      set_mode(POL_ROUND, 9'd0, 7'd0); // both counts clamp up to one
      send_fault(8'd0);
      send_fault(8'd1);
      set_mode(POL_RANDOM, 9'd511, 7'd127); // clamp down to the maximum
      send_fault(8'd170);
      send_fault(8'd85);
   endtask

   // A single frame under each policy, the unused code too: each fault needs a victim.
   task automatic test_no_victim();
      set_mode(POL_ROUND, 9'd256, 7'd1);
      send_fault(8'd254);
      set_mode(POL_ROUND, 9'd4, 7'd1);
      send_fault(8'd3);
      set_mode(POL_RANDOM, 9'd4, 7'd1);
      send_fault(8'd2);
      set_mode(2'd3, 9'd256, 7'd1);  // unused code, round robin
      send_fault(8'd7);
      set_mode(POL_FIFO, 9'd256, 7'd1); // victim taken from the ring head
      send_fault(8'd9);
   endtask

   // Working-set traffic across random register settings.
   task automatic test_random_traffic(int n_items);
      int np, nf, r;
      logic [7:0] last_page;
      last_page = '0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            r = $urandom_range(9);
            if (r == 0) np = 256;
            else if (r == 1) np = 0;
            else if (r == 2) np = 511;
            else if (r == 3) np = $urandom_range(511);
            else np = $urandom_range(16, 1);
            r = $urandom_range(9);
            if (r == 0) nf = 64;
            else if (r == 1) nf = 0;
            else if (r == 2) nf = 127;
            else nf = $urandom_range(8, 1);
            set_mode(2'($urandom_range(3)), 9'(np), 7'(nf));
         end
         np = active_pages();
         r  = $urandom_range(99);
         if (r < 80) begin
            // working set a little wider than the frames so evictions happen
            last_page = 8'($urandom_range((np < 24) ? np - 1 : 23));
            if (np > 24 && $urandom_range(3) == 0) last_page = 8'($urandom_range(np - 1));
         end else if (r < 92) begin
            last_page = 8'($urandom_range(255));
         end
         send_fault(last_page);  // otherwise repeat the last page to climb rights
      end
   endtask

   initial begin
      cfg_policy  = POLICY_RESET;
      cfg_pages   = PAGES_RESET;
      cfg_frames  = FRAMES_RESET;
      ring_head   = 0;
      ring_fill   = 0;
      rr_ptr      = 0;
      lfsr        = LFSR_RESET;
      fault_total = '0;
      read_total  = '0;
      write_total = '0;
      foreach (rights_tab[p]) begin
         rights_tab[p] = RIGHTS_NONE;
         frame_tab[p]  = '0;
      end
      foreach (frame_busy[f]) begin
         frame_busy[f] = 0;
         load_ring[f]  = '0;
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 75;
      test_rights_and_limits();
      test_no_victim();
      test_random_traffic(575);
      send_idle_pct = 75;
      recv_idle_pct = 34;
      test_random_traffic(575);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(575);

      drain();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
src/pfre_pkg.sv
src/pfre_ram.sv
src/pfre_mod.sv
src/page_fault_replacement_engine.sv
dv/testbench.sv
